@@ hw/rtl/ps2_mouse_packet_decoder_unit_defines.svh @@
// Assertion macros shared by the PS/2 mouse packet decoder RTL.
`ifndef PS2_MOUSE_PACKET_DECODER_UNIT_DEFINES_SVH
`define PS2_MOUSE_PACKET_DECODER_UNIT_DEFINES_SVH

// Check that expr holds in the cycle after cond.
`define PS2M_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

// Check that expr holds in the same cycle as cond.
`define PS2M_ASSERT_NOW(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

`endif

@@ hw/rtl/ps2m_pkg.sv @@
// Types and constants for the PS/2 mouse packet decoder.
`default_nettype none
package ps2m_pkg;

  // Input word kinds
  localparam logic ACT_DATA       = 1'b0;
  localparam logic ACT_WHEEL_READ = 1'b1;

  // Result word kinds
  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_WHEEL  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_WHEEL_MODE    = 2'd2;

  // Reset values
  localparam logic [15:0] SCREEN_WIDTH_RST  = 16'd2000;
  localparam logic [15:0] SCREEN_HEIGHT_RST = 16'd1500;
  localparam int          POINTER_X_RST     = 400;
  localparam int          POINTER_Y_RST     = 300;

  // Header byte bits
  localparam int HDR_SYNC_BIT   = 3;
  localparam int HDR_X_SIGN_BIT = 4;
  localparam int HDR_Y_SIGN_BIT = 5;
  localparam int HDR_X_OVF_BIT  = 6;
  localparam int HDR_Y_OVF_BIT  = 7;

  localparam logic [2:0] PKT_LEN_BASIC = 3'd3;
  localparam logic [2:0] PKT_LEN_WHEEL = 3'd4;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } ps2m_item_t;

  typedef struct packed {
    logic               result_kind;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic [2:0]         buttons;
    logic signed [15:0] wheel_notches;
  } ps2m_result_t;

  typedef struct packed {
    logic [15:0] screen_width;
    logic [15:0] screen_height;
    logic        wheel_mode;
  } ps2m_cfg_t;

  typedef struct packed {
    logic [1:0]         byte_phase;
    logic signed [15:0] wheel_total;
  } ps2m_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/ps2m_in_stage.sv @@
// Input register for incoming mouse words.
`default_nettype none
module ps2m_in_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // [7:0] data_byte
  input  wire logic                 s_tuser,   // [0] action
  input  wire logic                 advance,
  output logic                      in_valid,
  output ps2m_pkg::ps2m_item_t      in_item
);
  import ps2m_pkg::*;

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.action    <= s_tuser;
      in_item.data_byte <= s_tdata;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/ps2m_core.sv @@
// Packet assembly, pointer and wheel state, and result formation.
`default_nettype none
module ps2m_core #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 go,
  input  wire ps2m_pkg::ps2m_item_t item,
  input  wire ps2m_pkg::ps2m_cfg_t  cfg,
  output logic                      res_valid,
  output ps2m_pkg::ps2m_result_t    res,
  output ps2m_pkg::ps2m_status_t    status
);
  import ps2m_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int SW = CW + 2;
  localparam int HW = ((CW > 16) ? CW : 16) + 2;

  logic [CW-1:0]      pointer_x;
  logic [CW-1:0]      pointer_y;
  logic [2:0]         button_bits;
  logic signed [15:0] wheel_total;
  logic [1:0]         byte_phase;
  logic [7:0]         packet_bytes [4];

  logic [7:0]         b;
  logic [7:0]         hdr, b1, b2, b3;
  logic               drop;
  logic [2:0]         phase_inc;
  logic [2:0]         pkt_len;
  logic               done;
  logic               pkt_ok;
  logic signed [8:0]  dx, dy;
  logic signed [SW-1:0] sum_x, sum_y;
  logic [HW-1:0]      cmax_w, wm1_w, hm1_w, hi_x, hi_y;
  logic [CW-1:0]      x_new, y_new;
  logic signed [3:0]  wz;
  logic signed [16:0] wsum;
  logic signed [15:0] wheel_sat, wheel_new;

  function automatic logic [CW-1:0] clamp_pos(logic signed [SW-1:0] v, logic [HW-1:0] hi);
    logic [CW-1:0] r;
    if (v[SW-1]) begin
      r = '0;
    end else if (HW'(v[SW-2:0]) > hi) begin
      r = CW'(hi);
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  always_comb begin
    b         = item.data_byte;
    drop      = (byte_phase == 2'd0) && !b[HDR_SYNC_BIT];
    phase_inc = {1'b0, byte_phase} + 3'd1;
    pkt_len   = cfg.wheel_mode ? PKT_LEN_WHEEL : PKT_LEN_BASIC;
    done      = phase_inc >= pkt_len;

    // The completing byte is not stored yet: take it from the input.
    hdr = packet_bytes[0];
    b1  = (byte_phase == 2'd1) ? b : packet_bytes[1];
    b2  = (byte_phase == 2'd2) ? b : packet_bytes[2];
    b3  = (byte_phase == 2'd3) ? b : packet_bytes[3];

    pkt_ok = (item.action == ACT_DATA) && !drop && done &&
             !hdr[HDR_X_OVF_BIT] && !hdr[HDR_Y_OVF_BIT];

    dx    = {hdr[HDR_X_SIGN_BIT], b1};
    dy    = {hdr[HDR_Y_SIGN_BIT], b2};
    sum_x = $signed({2'b00, pointer_x}) + SW'(dx);
    sum_y = $signed({2'b00, pointer_y}) - SW'(dy);

    cmax_w = HW'({CW{1'b1}});
    wm1_w  = HW'(cfg.screen_width - 16'd1);
    hm1_w  = HW'(cfg.screen_height - 16'd1);
    hi_x   = (wm1_w > cmax_w) ? cmax_w : wm1_w;
    hi_y   = (hm1_w > cmax_w) ? cmax_w : hm1_w;

    x_new = pkt_ok ? clamp_pos(sum_x, hi_x) : pointer_x;
    y_new = pkt_ok ? clamp_pos(sum_y, hi_y) : pointer_y;

    wz   = b3[3:0];
    wsum = {wheel_total[15], wheel_total} + 17'(wz);
    if (wsum[16] != wsum[15]) begin
      wheel_sat = wsum[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      wheel_sat = wsum[15:0];
    end
    wheel_new = (pkt_ok && cfg.wheel_mode) ? wheel_sat : wheel_total;

    res_valid         = (item.action == ACT_WHEEL_READ) || pkt_ok;
    res.result_kind   = (item.action == ACT_WHEEL_READ) ? KIND_WHEEL : KIND_PACKET;
    res.pos_x         = 16'(x_new);
    res.pos_y         = 16'(y_new);
    res.buttons       = pkt_ok ? hdr[2:0] : button_bits;
    res.wheel_notches = (item.action == ACT_WHEEL_READ) ? wheel_total : wheel_new;

    status.byte_phase  = byte_phase;
    status.wheel_total = wheel_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer_x   <= CW'(POINTER_X_RST);
      pointer_y   <= CW'(POINTER_Y_RST);
      button_bits <= '0;
      wheel_total <= '0;
      byte_phase  <= '0;
    end else if (go) begin
      if (item.action == ACT_WHEEL_READ) begin
        wheel_total <= '0;
      end else if (!drop) begin
        byte_phase  <= done ? 2'd0 : phase_inc[1:0];
        pointer_x   <= x_new;
        pointer_y   <= y_new;
        button_bits <= res.buttons;
        wheel_total <= wheel_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && (item.action == ACT_DATA) && !drop) begin
      packet_bytes[byte_phase] <= b;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/ps2m_out_stage.sv @@
// Result register in front of the output stream.
`default_nettype none
module ps2m_out_stage (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire ps2m_pkg::ps2m_result_t res,
  input  wire logic                   m_tready,
  output logic                        m_tvalid,
  output ps2m_pkg::ps2m_result_t      out_res,
  output logic                        out_free
);
  import ps2m_pkg::*;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/ps2_mouse_packet_decoder_unit.sv @@
// Top level of the PS/2 mouse packet decoder.
`default_nettype none
`include "ps2_mouse_packet_decoder_unit_defines.svh"
// PS/2 mouse packet decoder. Each input word is either a raw mouse byte
// (tuser = 0) or a request to read and clear the wheel accumulator
// (tuser = 1). Bytes are dropped until a header with bit 3 set arrives;
// from there bytes form 3-byte packets, or 4-byte packets when wheel_mode
// is set. A finished packet without overflow bits moves the pointer by the
// sign-extended X delta and the inverted Y delta, clamps it to the screen
// size, latches the buttons and, in wheel mode, adds the wheel nibble into
// a saturating 16-bit total; it yields one result word. Dropped bytes,
// partial packets and overflowed packets yield nothing. A wheel read yields
// the current position, buttons and total, then clears the total.
// Throughput is one word per cycle while the result register is free: each
// word waits in the input register, and the combinational decode logic
// writes the result register as a word with a result advances, so m_tvalid
// rises once that register is loaded. The result register and the input
// register decouple the two sides; only a stalled full result register
// holds the input. Configuration writes are always accepted
// (cfg_ready is tied high); a zero screen size is ignored and unknown
// indexes are ignored. Write configuration only while no word is in flight.
module ps2_mouse_packet_decoder_unit #(
  parameter int COORD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] action
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [15:0] pos_x, [31:16] pos_y, [34:32] buttons,
                                      // [50:35] wheel_notches, [55:51] zero
  output logic             m_tuser,   // [0] result_kind
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import ps2m_pkg::*;

  ps2m_cfg_t    cfg;
  logic         in_valid;
  ps2m_item_t   in_item;
  logic         advance;
  logic         out_free;
  logic         core_res_valid;
  ps2m_result_t core_res;
  ps2m_result_t out_res;
  ps2m_status_t core_status;

  // Configuration registers: never stall the write channel.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= SCREEN_WIDTH_RST;
      cfg.screen_height <= SCREEN_HEIGHT_RST;
      cfg.wheel_mode    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH: begin
          // drop a zero size, keep the old bound
          if (cfg_data != 16'd0) cfg.screen_width <= cfg_data;
        end
        CFG_SCREEN_HEIGHT: begin
          if (cfg_data != 16'd0) cfg.screen_height <= cfg_data;
        end
        CFG_WHEEL_MODE: begin
          cfg.wheel_mode <= cfg_data[0];
        end
        default: begin
          // unused index: ignore the word
        end
      endcase
    end
  end

  // Advance the held word whenever the result register can take its answer.
  assign advance = in_valid && out_free;

  ps2m_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .in_valid (in_valid),
    .in_item  (in_item)
  );

  ps2m_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (advance),
    .item      (in_item),
    .cfg       (cfg),
    .res_valid (core_res_valid),
    .res       (core_res),
    .status    (core_status)
  );

  ps2m_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && core_res_valid),
    .res      (core_res),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .out_res  (out_res),
    .out_free (out_free)
  );

  // Pack the result word, first field in the low bits.
  assign m_tdata = {5'd0, out_res.wheel_notches, out_res.buttons,
                    out_res.pos_y, out_res.pos_x};
  assign m_tuser = out_res.result_kind;

  // A wheel read leaves the accumulator cleared.
  `PS2M_ASSERT_NEXT(a_wheel_clear, advance && (in_item.action == ACT_WHEEL_READ), core_status.wheel_total == 16'sd0, "wheel total not cleared after read")
  // A decoded packet always restarts byte collection.
  `PS2M_ASSERT_NEXT(a_phase_restart, advance && core_res_valid && (core_res.result_kind == KIND_PACKET), core_status.byte_phase == 2'd0, "byte phase not reset after packet")
  // A new result only appears after a word advanced out of the input register.
  `PS2M_ASSERT_NOW(a_result_source, $rose(m_tvalid), $past(advance), "result appeared without an advancing word")

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the PS/2 mouse packet decoder: random and directed byte streams.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2m_pkg::*;

  // Index that no register answers to; writes to it must leave every setting alone.
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  // Leave some margin before touching registers.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_PERCENT = 23;

  // Tracks pointer, buttons and wheel total the way the decoder should, and
  // holds the result words still owed by the block.
  class mouse_tracker;
    logic [15:0]        width_lim;
    logic [15:0]        height_lim;
    logic               wheel_on;
    logic [1:0]         phase;
    logic [7:0]         pkt [4];
    logic [15:0]        px;
    logic [15:0]        py;
    logic [2:0]         btn;
    logic signed [15:0] wheel;
    ps2m_result_t       expected_reports [$];
    int                 mismatches;

    function new();
      width_lim  = SCREEN_WIDTH_RST;
      height_lim = SCREEN_HEIGHT_RST;
      wheel_on   = 1'b0;
      phase      = 2'd0;
      px         = 16'(POINTER_X_RST);
      py         = 16'(POINTER_Y_RST);
      btn        = 3'd0;
      wheel      = 16'sd0;
      mismatches = 0;
    endfunction

    function logic [15:0] clamp_coord(int v, logic [15:0] lim);
      int top;
      top = int'(lim) - 1;
      if (v < 0) return 16'd0;
      if (v > top) return top[15:0];
      return v[15:0];
    endfunction

    // A zero screen size and the unused index leave the settings unchanged.
    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_SCREEN_WIDTH:  if (val != 16'd0) width_lim = val;
        CFG_SCREEN_HEIGHT: if (val != 16'd0) height_lim = val;
        CFG_WHEEL_MODE:    wheel_on = val[0];
        default: ;
      endcase
    endfunction

    function void push_report(logic kind, logic signed [15:0] notches);
      ps2m_result_t r;
      r.result_kind   = kind;
      r.pos_x         = px;
      r.pos_y         = py;
      r.buttons       = btn;
      r.wheel_notches = notches;
      expected_reports.push_back(r);
    endfunction

    function void note_word(ps2m_item_t w);
      int         nxt;
      int         dx;
      int         dy;
      int         wz;
      int         sum;
      logic [7:0] hdr;
      if (w.action == ACT_WHEEL_READ) begin
        push_report(KIND_WHEEL, wheel);
        wheel = 16'sd0;
        return;
      end
      // Hunt for a header with the sync bit before collecting anything.
      if (phase == 2'd0 && !w.data_byte[HDR_SYNC_BIT]) return;
      pkt[phase] = w.data_byte;
      nxt = int'(phase) + 1;
      // A mode switch mid-packet can leave the count at or past the new length.
      if (nxt < (wheel_on ? int'(PKT_LEN_WHEEL) : int'(PKT_LEN_BASIC))) begin
        phase = nxt[1:0];
        return;
      end
      phase = 2'd0;
      hdr = pkt[0];
      if (hdr[HDR_X_OVF_BIT] || hdr[HDR_Y_OVF_BIT]) return;
      dx = int'(pkt[1]) - (hdr[HDR_X_SIGN_BIT] ? 256 : 0);
      dy = int'(pkt[2]) - (hdr[HDR_Y_SIGN_BIT] ? 256 : 0);
      px = clamp_coord(int'(px) + dx, width_lim);
      py = clamp_coord(int'(py) - dy, height_lim);
      btn = hdr[2:0];
      if (wheel_on) begin
        wz = int'(pkt[3][3:0]) - (pkt[3][3] ? 16 : 0);
        sum = int'(wheel) + wz;
        if (sum > 32767) sum = 32767;
        if (sum < -32768) sum = -32768;
        wheel = sum[15:0];
      end
      push_report(KIND_PACKET, wheel);
    endfunction

    function void compare_field(string field, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(ps2m_result_t got);
      ps2m_result_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result word kind=%0d x=%0d y=%0d buttons=%0d wheel=%0d",
                 $time, got.result_kind, got.pos_x, got.pos_y, got.buttons,
                 got.wheel_notches);
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("result_kind", want.result_kind, got.result_kind);
      compare_field("pos_x", want.pos_x, got.pos_x);
      compare_field("pos_y", want.pos_y, got.pos_y);
      compare_field("buttons", want.buttons, got.buttons);
      compare_field("wheel_notches", want.wheel_notches, got.wheel_notches);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire logic   s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tuser = ACT_DATA;
  wire logic   m_tvalid;
  logic        m_tready = 1'b0;
  wire logic [55:0] m_tdata;
  wire logic   m_tuser;
  logic        cfg_valid = 1'b0;
  wire logic   cfg_ready;
  logic [1:0]  cfg_index = CFG_SCREEN_WIDTH;
  logic [15:0] cfg_data = 16'd0;

  mouse_tracker tracker = new();

  // Quiet stretch: neither side idles while this is set.
  bit calm = 1'b0;
  // Long receiver hold-offs asked by the stimulus, and those already served.
  int hold_asks = 0;
  int hold_done = 0;
  int hold_left = 0;
  int cycles = 0;

  ps2_mouse_packet_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Watchdog: give up if the run drags on far past its slowest correct length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: drop ready at random, except in quiet stretches; serve a long
  // hold-off when the stimulus asks for one so the input side backs up.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_asks != hold_done) begin
      hold_done = hold_asks;
      hold_left = HOLD_OFF_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Check every result word accepted on the master side.
  always @(posedge clk) begin : watch_results
    ps2m_result_t got;
    got.result_kind   = m_tuser;
    got.pos_x         = m_tdata[15:0];
    got.pos_y         = m_tdata[31:16];
    got.buttons       = m_tdata[34:32];
    got.wheel_notches = m_tdata[50:35];
    if (!rst && m_tvalid && m_tready) tracker.check_report(got);
  end

  // Offer one word, idling first at random outside quiet stretches; hold
  // valid high afterwards so back-to-back words need no extra edge.
  task automatic send_word(logic act, logic [7:0] b);
    ps2m_item_t item;
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    item.action    = act;
    item.data_byte = b;
    tracker.note_word(item);
  endtask

  // Send a whole packet; the wheel byte goes out only in wheel mode.
  task automatic send_packet(logic [7:0] hdr, logic [7:0] x, logic [7:0] y, logic [7:0] z);
    send_word(ACT_DATA, hdr);
    send_word(ACT_DATA, x);
    send_word(ACT_DATA, y);
    if (tracker.wheel_on) send_word(ACT_DATA, z);
  endtask

  // Stop offering words and wait until every owed result is back, then let
  // any trailing byte with no result settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, val);
  endtask

  task automatic apply_setup(logic [15:0] w, logic [15:0] h, logic mode);
    drain();
    cfg_write(CFG_SCREEN_WIDTH, w);
    cfg_write(CFG_SCREEN_HEIGHT, h);
    cfg_write(CFG_WHEEL_MODE, {15'd0, mode});
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed packets with random content; the rest are wheel
  // reads, loose bytes and packets cut short.
  task automatic random_burst(int count);
    int         sent;
    int         pick;
    logic [7:0] hdr;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      hdr = 8'($urandom);
      hdr[HDR_SYNC_BIT] = 1'b1;
      if (pick < 10) begin
        send_word(ACT_WHEEL_READ, 8'($urandom));
        sent++;
      end else if (pick < 16) begin
        send_word(ACT_DATA, 8'($urandom));
        sent++;
      end else if (pick < 20) begin
        send_word(ACT_DATA, hdr);
        send_word(ACT_DATA, 8'($urandom));
        sent += 2;
      end else begin
        if ($urandom_range(0, 7) != 0) begin
          hdr[HDR_X_OVF_BIT] = 1'b0;
          hdr[HDR_Y_OVF_BIT] = 1'b0;
        end
        send_packet(hdr, 8'($urandom), 8'($urandom), 8'($urandom));
        sent += tracker.wheel_on ? 4 : 3;
      end
    end
  endtask

  // Long run of clean wheel packets carrying the same wheel step, to walk
  // the total steadily in one direction, then read it back.
  task automatic wheel_run(int packets, logic [3:0] step);
    logic [7:0] hdr;
    repeat (packets) begin
      hdr = 8'($urandom);
      hdr[HDR_SYNC_BIT]  = 1'b1;
      hdr[HDR_X_OVF_BIT] = 1'b0;
      hdr[HDR_Y_OVF_BIT] = 1'b0;
      send_packet(hdr, 8'($urandom), 8'($urandom), {4'($urandom), step});
    end
    send_word(ACT_WHEEL_READ, 8'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset state shows up on a wheel read.
    send_word(ACT_WHEEL_READ, 8'hFF);
    // Bytes without the sync bit are dropped while hunting for a header.
    send_word(ACT_DATA, 8'h00);
    send_word(ACT_DATA, 8'hF7);
    // Largest positive and negative deltas, all buttons then none.
    send_packet(8'h0F, 8'hFF, 8'hFF, 8'h00);
    send_packet(8'h38, 8'h00, 8'h00, 8'h00);
    // Overflowed packets are swallowed.
    send_packet(8'hC8, 8'h12, 8'h34, 8'h00);
    send_packet(8'h48, 8'h7F, 8'h01, 8'h00);

    // Zero sizes and the unused index are ignored; switch to wheel packets.
    drain();
    cfg_write(CFG_SCREEN_WIDTH, 16'd0);
    cfg_write(CFG_SCREEN_HEIGHT, 16'd0);
    cfg_write(CFG_UNUSED, 16'hFFFF);
    cfg_write(CFG_WHEEL_MODE, 16'd1);
    cfg_valid <= 1'b0;
    send_packet(8'h09, 8'h01, 8'h01, 8'h07);
    send_packet(8'h0A, 8'h00, 8'h00, 8'hF8);
    send_word(ACT_WHEEL_READ, 8'h00);

    // Leave three bytes of a wheel packet, drop to three-byte mode, and let
    // the next byte finish the packet.
    send_word(ACT_DATA, 8'h0C);
    send_word(ACT_DATA, 8'h10);
    send_word(ACT_DATA, 8'hF0);
    drain();
    cfg_write(CFG_WHEEL_MODE, 16'd0);
    cfg_valid <= 1'b0;
    send_word(ACT_DATA, 8'h80);

    // Smallest screen pins the pointer at the origin.
    apply_setup(16'd1, 16'd1, 1'b0);
    random_burst(200);

    apply_setup(16'hFFFF, 16'hFFFF, 1'b1);
    random_burst(300);

    // Hold the receiver off while words keep coming so the input stalls.
    apply_setup(16'($urandom_range(1, 640)), 16'($urandom_range(1, 480)),
                1'($urandom));
    hold_asks <= hold_asks + 1;
    random_burst(150);
    // Pause the sender until the block has handed back everything.
    drain();
    random_burst(150);

    calm = 1'b1;
    apply_setup(16'd800, 16'd600, 1'b1);
    random_burst(300);
    calm = 1'b0;

    apply_setup(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                1'($urandom));
    random_burst(300);

    apply_setup(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, 1'b0);
    random_burst(100);

    apply_setup(16'($urandom_range(100, 3000)), 16'($urandom_range(100, 3000)),
                1'b1);
    random_burst(200);

    // Long runs of one wheel step up, then down, without idling.
    apply_setup(16'd1024, 16'd768, 1'b1);
    calm = 1'b1;
    wheel_run(25, 4'h7);
    wheel_run(25, 4'h8);
    calm = 1'b0;

    drain();
    if (tracker.mismatches == 0 && tracker.expected_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ps2m_pkg.sv
hw/rtl/ps2m_in_stage.sv
hw/rtl/ps2m_core.sv
hw/rtl/ps2m_out_stage.sv
hw/rtl/ps2_mouse_packet_decoder_unit.sv
sim/testbench.sv
